### hdl/rgdfs_pkg.sv
// ----------------------------------------------------------------------------
// rgdfs_pkg
// Types, sizes and codes shared by the reverse-graph search block and its
// channel interfaces.
// ----------------------------------------------------------------------------
package rgdfs_pkg;

    localparam int MAX_NODES = 1024;
    localparam int MAX_EDGES = 4096;

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int NCNT_W = NODE_W + 1;
    localparam int EIDX_W = $clog2(MAX_EDGES);
    localparam int ECNT_W = EIDX_W + 1;

    typedef logic [NODE_W-1:0] node_t;
    typedef logic [NCNT_W-1:0] ncnt_t;
    typedef logic [EIDX_W-1:0] eidx_t;
    typedef logic [ECNT_W-1:0] ecnt_t;

    typedef enum logic [0:0] {
        REQ_LOAD = 1'b0,
        REQ_READ = 1'b1
    } req_type_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_RANGE     = 2'd1,
        STATUS_LOAD_ERR  = 2'd2,
        STATUS_NOT_BUILT = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RD,
        ST_CLR,
        ST_CNT_A,
        ST_CNT_B,
        ST_CNT_C,
        ST_PS_A,
        ST_PS_B,
        ST_SC_A,
        ST_SC_B,
        ST_SC_C,
        ST_OUT_A,
        ST_OUT_B,
        ST_OUT_C,
        ST_TOP_A,
        ST_TOP_B,
        ST_TOP_C,
        ST_TOP_CHK,
        ST_TOP_D,
        ST_TOP_E,
        ST_TOP_F,
        ST_FIN_A,
        ST_FIN_B
    } state_t;

endpackage

### hdl/rgdfs_req_if.sv
// ----------------------------------------------------------------------------
// rgdfs_req_if
// Request channel: edge loads and list reads, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rgdfs_req_if;
    import rgdfs_pkg::*;

    logic      valid;
    logic      ready;
    req_type_t req_type;
    node_t     edge_from;
    node_t     edge_to;
    logic      last_edge;
    node_t     read_pos;

    modport source (output valid, req_type, edge_from, edge_to, last_edge, read_pos,
                    input ready);
    modport sink (input valid, req_type, edge_from, edge_to, last_edge, read_pos,
                  output ready);
endinterface

### hdl/rgdfs_rsp_if.sv
// ----------------------------------------------------------------------------
// rgdfs_rsp_if
// Response channel: one word per list read, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rgdfs_rsp_if;
    import rgdfs_pkg::*;

    logic    valid;
    logic    ready;
    node_t   node_id;
    status_t status;

    modport source (output valid, node_id, status, input ready);
    modport sink (input valid, node_id, status, output ready);
endinterface

### hdl/reverse_graph_dfs_postorder.sv
// ----------------------------------------------------------------------------
// reverse_graph_dfs_postorder
// Sink-priority order of a directed graph by depth-first search over the
// reverse edges.
//
// Usage. Edges are loaded on the req channel, one word per cycle while the
// block is idle. A load word with last_edge set starts the build: in-degree
// count, prefix sum, scatter into a compressed reverse adjacency, then the
// search and the placement of the list. The block is not ready during the
// build. With n the node count in use, the build first clears the counts
// and visited marks of the n nodes, then runs the count over the kept edges,
// the prefix sum over the nodes, the scatter over the kept edges, the search
// from each unvisited root over the nodes and kept edges, and the placement.
// Every step goes through memories with one write port and one registered
// read port, under one sequencer.
// A read word returns one word on the rsp channel; a load returns none. The
// list memory is read as the read is taken, and ST_RD moves the result into
// the registered rsp word. A read taken while the rsp word waits is held
// until the receiver takes the waiting word; the block is not ready in ST_RD.
// Writing cfg_wdata with cfg_we discards the loaded edges and the list.
// Reset gives node_count 1, no edges and no list; no clearing pass runs.
// ----------------------------------------------------------------------------
module reverse_graph_dfs_postorder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  rgdfs_pkg::ncnt_t   cfg_wdata,
    rgdfs_req_if.sink          req,
    rgdfs_rsp_if.source        rsp
);
    import rgdfs_pkg::*;

    state_t  state_reg, state_next;
    ecnt_t   idx_reg, idx_next;
    ecnt_t   acc_reg, acc_next;
    ecnt_t   cur_reg, cur_next;
    ecnt_t   end_reg, end_next;
    node_t   top_reg, top_next;
    node_t   c_reg, c_next;
    ncnt_t   sp_reg, sp_next;
    ncnt_t   posts_reg, posts_next;
    ncnt_t   i_reg, i_next;
    ncnt_t   nodes_reg, nodes_next;
    ecnt_t   total_reg, total_next;
    logic    built_reg, built_next;
    logic    lerr_reg, lerr_next;
    logic    out_valid_reg, out_valid_next;
    node_t   out_node_reg, out_node_next;
    status_t out_status_reg, out_status_next;
    status_t rd_status_reg, rd_status_next;

    // Memories
    node_t src_mem [MAX_EDGES];
    node_t dst_mem [MAX_EDGES];
    ecnt_t cnt_mem [MAX_NODES];
    ecnt_t rs_mem  [MAX_NODES+1];
    node_t rl_mem  [MAX_EDGES];
    logic  vis_mem [MAX_NODES];
    node_t stk_mem [MAX_NODES];
    node_t po_mem  [MAX_NODES];
    node_t sk_mem  [MAX_NODES];

    logic  e_we, e_re;
    eidx_t e_wa;
    node_t src_wd, dst_wd, src_rd, dst_rd;
    logic  cnt_we, cnt_re;
    node_t cnt_wa, cnt_ra;
    ecnt_t cnt_wd, cnt_rd;
    logic  rs_we, rs_re;
    ncnt_t rs_wa, rs_ra;
    ecnt_t rs_wd, rs_rd;
    logic  rl_we, rl_re;
    eidx_t rl_wa, rl_ra;
    node_t rl_wd, rl_rd;
    logic  vis_we, vis_re, vis_wd, vis_rd;
    node_t vis_wa, vis_ra;
    logic  stk_we, stk_re;
    node_t stk_wa, stk_ra, stk_wd, stk_rd;
    logic  po_we, po_re;
    node_t po_wa, po_ra, po_wd, po_rd;
    logic  sk_we, sk_re;
    node_t sk_wa, sk_ra, sk_wd, sk_rd;

    logic  load_bad;
    ecnt_t nodes_e;
    ncnt_t fin_pos;
    ncnt_t sp_dec;

    assign nodes_e = ECNT_W'(nodes_reg);
    assign fin_pos = nodes_reg - NCNT_W'(1) - NCNT_W'(po_rd);
    assign sp_dec  = sp_reg - NCNT_W'(1);

    always_ff @(posedge clk)
    begin
        if (e_we)
        begin
            src_mem[e_wa] <= src_wd;
            dst_mem[e_wa] <= dst_wd;
        end
        if (e_re)
        begin
            src_rd <= src_mem[idx_reg[EIDX_W-1:0]];
            dst_rd <= dst_mem[idx_reg[EIDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
            cnt_mem[cnt_wa] <= cnt_wd;
        if (cnt_re)
            cnt_rd <= cnt_mem[cnt_ra];
    end

    always_ff @(posedge clk)
    begin
        if (rs_we)
            rs_mem[rs_wa] <= rs_wd;
        if (rs_re)
            rs_rd <= rs_mem[rs_ra];
    end

    always_ff @(posedge clk)
    begin
        if (rl_we)
            rl_mem[rl_wa] <= rl_wd;
        if (rl_re)
            rl_rd <= rl_mem[rl_ra];
    end

    always_ff @(posedge clk)
    begin
        if (vis_we)
            vis_mem[vis_wa] <= vis_wd;
        if (vis_re)
            vis_rd <= vis_mem[vis_ra];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
            stk_mem[stk_wa] <= stk_wd;
        if (stk_re)
            stk_rd <= stk_mem[stk_ra];
    end

    always_ff @(posedge clk)
    begin
        if (po_we)
            po_mem[po_wa] <= po_wd;
        if (po_re)
            po_rd <= po_mem[po_ra];
    end

    always_ff @(posedge clk)
    begin
        if (sk_we)
            sk_mem[sk_wa] <= sk_wd;
        if (sk_re)
            sk_rd <= sk_mem[sk_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            acc_reg        <= '0;
            cur_reg        <= '0;
            end_reg        <= '0;
            top_reg        <= '0;
            c_reg          <= '0;
            sp_reg         <= '0;
            posts_reg      <= '0;
            i_reg          <= '0;
            nodes_reg      <= NCNT_W'(1);
            total_reg      <= '0;
            built_reg      <= 1'b0;
            lerr_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            rd_status_reg  <= STATUS_OK;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            acc_reg        <= acc_next;
            cur_reg        <= cur_next;
            end_reg        <= end_next;
            top_reg        <= top_next;
            c_reg          <= c_next;
            sp_reg         <= sp_next;
            posts_reg      <= posts_next;
            i_reg          <= i_next;
            nodes_reg      <= nodes_next;
            total_reg      <= total_next;
            built_reg      <= built_next;
            lerr_reg       <= lerr_next;
            out_valid_reg  <= out_valid_next;
            rd_status_reg  <= rd_status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_node_reg   <= out_node_next;
        out_status_reg <= out_status_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        acc_next        = acc_reg;
        cur_next        = cur_reg;
        end_next        = end_reg;
        top_next        = top_reg;
        c_next          = c_reg;
        sp_next         = sp_reg;
        posts_next      = posts_reg;
        i_next          = i_reg;
        nodes_next      = nodes_reg;
        total_next      = total_reg;
        built_next      = built_reg;
        lerr_next       = lerr_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_node_next   = out_node_reg;
        out_status_next = out_status_reg;
        rd_status_next  = rd_status_reg;
        load_bad        = 1'b0;

        e_we   = 1'b0;  e_wa   = total_reg[EIDX_W-1:0];
        src_wd = req.edge_from;  dst_wd = req.edge_to;  e_re = 1'b0;
        cnt_we = 1'b0;  cnt_wa = idx_reg[NODE_W-1:0];  cnt_wd = '0;
        cnt_re = 1'b0;  cnt_ra = idx_reg[NODE_W-1:0];
        rs_we  = 1'b0;  rs_wa  = '0;  rs_wd = '0;  rs_re = 1'b0;  rs_ra = '0;
        rl_we  = 1'b0;  rl_wa  = cnt_rd[EIDX_W-1:0];  rl_wd = src_rd;
        rl_re  = 1'b0;  rl_ra  = cur_reg[EIDX_W-1:0];
        vis_we = 1'b0;  vis_wa = idx_reg[NODE_W-1:0];  vis_wd = 1'b0;
        vis_re = 1'b0;  vis_ra = i_reg[NODE_W-1:0];
        stk_we = 1'b0;  stk_wa = sp_reg[NODE_W-1:0];  stk_wd = c_reg;
        stk_re = 1'b0;  stk_ra = sp_dec[NODE_W-1:0];
        po_we  = 1'b0;  po_wa  = top_reg;  po_wd = posts_reg[NODE_W-1:0];
        po_re  = 1'b0;  po_ra  = idx_reg[NODE_W-1:0];
        sk_we  = 1'b0;  sk_wa  = fin_pos[NODE_W-1:0];  sk_wd = idx_reg[NODE_W-1:0];
        sk_re  = 1'b0;  sk_ra  = req.read_pos;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.req_type == REQ_READ)
                    begin
                        sk_re = 1'b1;
                        if (!built_reg)
                            rd_status_next = STATUS_NOT_BUILT;
                        else if (lerr_reg)
                            rd_status_next = STATUS_LOAD_ERR;
                        else if (NCNT_W'(req.read_pos) >= nodes_reg)
                            rd_status_next = STATUS_RANGE;
                        else
                            rd_status_next = STATUS_OK;
                        state_next = ST_RD;
                    end
                    else
                    begin
                        if (built_reg)
                        begin
                            total_next = '0;
                            built_next = 1'b0;
                            lerr_next  = 1'b0;
                        end
                        load_bad = (total_next >= ECNT_W'(MAX_EDGES))
                                || (NCNT_W'(req.edge_from) >= nodes_reg)
                                || (NCNT_W'(req.edge_to) >= nodes_reg);
                        e_wa = total_next[EIDX_W-1:0];
                        if (load_bad)
                            lerr_next = 1'b1;
                        else
                        begin
                            e_we       = 1'b1;
                            total_next = total_next + ECNT_W'(1);
                        end
                        if (req.last_edge)
                        begin
                            idx_next   = '0;
                            state_next = ST_CLR;
                        end
                    end
                end
            end

            ST_RD:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = rd_status_reg;
                    out_node_next   = (rd_status_reg == STATUS_OK) ? sk_rd : '0;
                    state_next      = ST_IDLE;
                end
            end

            ST_CLR:
            begin
                cnt_we = 1'b1;
                vis_we = 1'b1;
                if (idx_reg == '0)
                    rs_we = 1'b1;
                idx_next = idx_reg + ECNT_W'(1);
                if (idx_next == nodes_e)
                begin
                    idx_next   = '0;
                    state_next = ST_CNT_A;
                end
            end

            ST_CNT_A:
            begin
                if (idx_reg == total_reg)
                begin
                    idx_next   = '0;
                    acc_next   = '0;
                    state_next = ST_PS_A;
                end
                else
                begin
                    e_re       = 1'b1;
                    state_next = ST_CNT_B;
                end
            end

            ST_CNT_B:
            begin
                cnt_re     = 1'b1;
                cnt_ra     = dst_rd;
                state_next = ST_CNT_C;
            end

            ST_CNT_C:
            begin
                cnt_we     = 1'b1;
                cnt_wa     = dst_rd;
                cnt_wd     = cnt_rd + ECNT_W'(1);
                idx_next   = idx_reg + ECNT_W'(1);
                state_next = ST_CNT_A;
            end

            ST_PS_A:
            begin
                if (idx_reg == nodes_e)
                begin
                    idx_next   = '0;
                    state_next = ST_SC_A;
                end
                else
                begin
                    cnt_re     = 1'b1;
                    state_next = ST_PS_B;
                end
            end

            ST_PS_B:
            begin
                rs_we      = 1'b1;
                rs_wa      = NCNT_W'(idx_reg + ECNT_W'(1));
                rs_wd      = acc_reg + cnt_rd;
                cnt_we     = 1'b1;
                cnt_wd     = acc_reg;
                acc_next   = acc_reg + cnt_rd;
                idx_next   = idx_reg + ECNT_W'(1);
                state_next = ST_PS_A;
            end

            ST_SC_A:
            begin
                if (idx_reg == total_reg)
                begin
                    i_next     = '0;
                    sp_next    = '0;
                    posts_next = '0;
                    state_next = ST_OUT_A;
                end
                else
                begin
                    e_re       = 1'b1;
                    state_next = ST_SC_B;
                end
            end

            ST_SC_B:
            begin
                cnt_re     = 1'b1;
                cnt_ra     = dst_rd;
                state_next = ST_SC_C;
            end

            ST_SC_C:
            begin
                rl_we      = 1'b1;
                cnt_we     = 1'b1;
                cnt_wa     = dst_rd;
                cnt_wd     = cnt_rd + ECNT_W'(1);
                idx_next   = idx_reg + ECNT_W'(1);
                state_next = ST_SC_A;
            end

            ST_OUT_A:
            begin
                if (i_reg == nodes_reg)
                begin
                    idx_next   = '0;
                    state_next = ST_FIN_A;
                end
                else
                begin
                    vis_re     = 1'b1;
                    state_next = ST_OUT_B;
                end
            end

            ST_OUT_B:
            begin
                if (vis_rd)
                begin
                    i_next     = i_reg + NCNT_W'(1);
                    state_next = ST_OUT_A;
                end
                else
                begin
                    vis_we     = 1'b1;
                    vis_wa     = i_reg[NODE_W-1:0];
                    vis_wd     = 1'b1;
                    stk_we     = 1'b1;
                    stk_wa     = '0;
                    stk_wd     = i_reg[NODE_W-1:0];
                    sp_next    = NCNT_W'(1);
                    rs_re      = 1'b1;
                    rs_ra      = i_reg;
                    state_next = ST_OUT_C;
                end
            end

            ST_OUT_C:
            begin
                cnt_we     = 1'b1;
                cnt_wa     = i_reg[NODE_W-1:0];
                cnt_wd     = rs_rd;
                state_next = ST_TOP_A;
            end

            ST_TOP_A:
            begin
                stk_re     = 1'b1;
                state_next = ST_TOP_B;
            end

            ST_TOP_B:
            begin
                top_next   = stk_rd;
                cnt_re     = 1'b1;
                cnt_ra     = stk_rd;
                rs_re      = 1'b1;
                rs_ra      = NCNT_W'(stk_rd) + NCNT_W'(1);
                state_next = ST_TOP_C;
            end

            ST_TOP_C:
            begin
                cur_next   = cnt_rd;
                end_next   = rs_rd;
                state_next = ST_TOP_CHK;
            end

            ST_TOP_CHK:
            begin
                if (cur_reg < end_reg)
                begin
                    rl_re      = 1'b1;
                    state_next = ST_TOP_D;
                end
                else
                begin
                    po_we      = 1'b1;
                    posts_next = posts_reg + NCNT_W'(1);
                    sp_next    = sp_dec;
                    if (sp_reg == NCNT_W'(1))
                    begin
                        i_next     = i_reg + NCNT_W'(1);
                        state_next = ST_OUT_A;
                    end
                    else
                        state_next = ST_TOP_A;
                end
            end

            ST_TOP_D:
            begin
                c_next     = rl_rd;
                vis_re     = 1'b1;
                vis_ra     = rl_rd;
                state_next = ST_TOP_E;
            end

            ST_TOP_E:
            begin
                if (!vis_rd)
                begin
                    vis_we     = 1'b1;
                    vis_wa     = c_reg;
                    vis_wd     = 1'b1;
                    stk_we     = 1'b1;
                    sp_next    = sp_reg + NCNT_W'(1);
                    rs_re      = 1'b1;
                    rs_ra      = NCNT_W'(c_reg);
                    state_next = ST_TOP_F;
                end
                else
                begin
                    cur_next   = cur_reg + ECNT_W'(1);
                    cnt_we     = 1'b1;
                    cnt_wa     = top_reg;
                    cnt_wd     = cur_reg + ECNT_W'(1);
                    state_next = ST_TOP_CHK;
                end
            end

            ST_TOP_F:
            begin
                cnt_we     = 1'b1;
                cnt_wa     = c_reg;
                cnt_wd     = rs_rd;
                state_next = ST_TOP_A;
            end

            ST_FIN_A:
            begin
                if (idx_reg == nodes_e)
                begin
                    built_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    po_re      = 1'b1;
                    state_next = ST_FIN_B;
                end
            end

            ST_FIN_B:
            begin
                sk_we      = 1'b1;
                idx_next   = idx_reg + ECNT_W'(1);
                state_next = ST_FIN_A;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            if (cfg_wdata == '0)
                nodes_next = NCNT_W'(1);
            else if (cfg_wdata > NCNT_W'(MAX_NODES))
                nodes_next = NCNT_W'(MAX_NODES);
            else
                nodes_next = cfg_wdata;
            total_next = '0;
            built_next = 1'b0;
            lerr_next  = 1'b0;
        end
    end

    assign req.ready   = (state_reg == ST_IDLE);
    assign rsp.valid   = out_valid_reg;
    assign rsp.node_id = out_node_reg;
    assign rsp.status  = out_status_reg;

    a_cfg_clears_list: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !built_reg)
        else $error("List still marked built after a configuration write.");

    a_err_node_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != STATUS_OK) |-> rsp.node_id == '0)
        else $error("Error word carries a non-zero node.");

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= nodes_reg)
        else $error("Search stack deeper than the node count.");

    a_stack_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TOP_CHK || state_reg == ST_TOP_A) |-> sp_reg != '0)
        else $error("Search step with an empty stack.");

endmodule
